@@ sv/stream_delimiter_splitter_defines.svh @@
// ----------------------------------------------------------------------------
// Stream delimiter splitter assertion macros
// Concurrent assertion shorthands shared by the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef STREAM_DELIMITER_SPLITTER_DEFINES_SVH
`define STREAM_DELIMITER_SPLITTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sds_pkg.sv @@
// ----------------------------------------------------------------------------
// Stream delimiter splitter package
// Sizes, result kind codes, register indexes and the window cell command.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MAX_DELIM = 16;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = $clog2(MAX_DELIM);
  localparam int FILL_W    = $clog2(MAX_DELIM + 1);
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int DELIM_W   = MAX_DELIM * BYTE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_HIGH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // command broadcast to every window cell
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
  } cell_op_t;

endpackage

@@ sv/stream_delimiter_splitter.sv @@
// ----------------------------------------------------------------------------
// Stream delimiter splitter
// Splits a byte stream at a configured delimiter of up to 16 bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): data_byte, or end_of_stream = 1 to flush.
// Output channel (out_valid/out_stall): out_byte, kind (data, delimiter found,
// end of stream) and last_of_run on the final result of each request.
// Config channel (cfg_valid/cfg_ready, always ready): match_len, then the two
// 64-bit delimiter words; write only while the block is idle.
// A request waits in the input register; its results are registered on the
// output. A data byte that completes a delimiter while the window was full
// pops the oldest byte, then gives the marker. End of stream drains every
// window byte, then gives the end marker; after a lowered match_len, extra
// bytes drain first. The window cell row steps once per cycle unless stalled.
// Reset empties the window and clears the control and config registers; the
// window bytes themselves are not cleared, no clearing pass.
// When the receiver stalls, the output register holds. Requests that only
// fill the window keep being taken; the first that needs the output waits in
// the input register and stalls the input.
// ----------------------------------------------------------------------------
`include "stream_delimiter_splitter_defines.svh"

module stream_delimiter_splitter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sds_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            end_of_stream,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sds_pkg::BYTE_W-1:0]      out_byte,
  output logic [1:0]                      kind,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sds_pkg::CFG_W-1:0]       cfg_data
);

  logic [sds_pkg::LEN_W-1:0]     match_len;
  logic [sds_pkg::CFG_W-1:0]     match_word_low;
  logic [sds_pkg::CFG_W-1:0]     match_word_high;

  logic                          pend_valid;
  logic [sds_pkg::BYTE_W-1:0]    pend_data;
  logic                          pend_eos;
  logic                          owe_delim;
  logic                          owe_delim_next;
  logic [sds_pkg::FILL_W-1:0]    fill;
  logic [sds_pkg::FILL_W-1:0]    fill_next;
  logic [sds_pkg::FILL_W-1:0]    fill_inc;
  logic [sds_pkg::FILL_W-1:0]    len;
  logic [sds_pkg::MAX_DELIM-1:0] active;

  sds_pkg::cell_op_t             op;
  logic [sds_pkg::BYTE_W-1:0]    oldest;
  logic                          match;

  logic                          emits;
  sds_pkg::kind_t                e_kind;
  logic [sds_pkg::BYTE_W-1:0]    e_byte;
  logic                          e_last;
  logic                          done;
  logic                          emit_ok;
  logic                          go;
  logic                          accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_len       <= '0;
      match_word_low  <= '0;
      match_word_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sds_pkg::CFG_MATCH_LEN: match_len       <= cfg_data[sds_pkg::LEN_W-1:0];
        sds_pkg::CFG_WORD_LOW:  match_word_low  <= cfg_data;
        sds_pkg::CFG_WORD_HIGH: match_word_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len = (match_len > sds_pkg::LEN_W'(sds_pkg::MAX_DELIM)) ?
               sds_pkg::FILL_W'(sds_pkg::MAX_DELIM) : sds_pkg::FILL_W'(match_len);

  always_comb begin
    for (int i = 0; i < sds_pkg::MAX_DELIM; i++) begin
      active[i] = (sds_pkg::FILL_W'(i) < len);
    end
  end

  sds_window u_window (
    .clk    (clk),
    .en     (go),
    .op     (op),
    .delim  ({match_word_high, match_word_low}),
    .active (active),
    .oldest (oldest),
    .match  (match)
  );

  assign fill_inc = fill + sds_pkg::FILL_W'(1);

  // one window step per cycle for the request held in the input register, unless the output stalls
  always_comb begin
    op             = '0;
    op.data        = pend_data;
    emits          = 1'b0;
    e_kind         = sds_pkg::KIND_DATA;
    e_byte         = '0;
    e_last         = 1'b0;
    done           = 1'b0;
    fill_next      = fill;
    owe_delim_next = owe_delim;
    if (pend_valid) begin
      if (owe_delim) begin
        emits          = 1'b1;
        e_kind         = sds_pkg::KIND_DELIM;
        e_last         = 1'b1;
        done           = 1'b1;
        fill_next      = '0;
        owe_delim_next = 1'b0;
      end else if (pend_eos) begin
        emits = 1'b1;
        if (fill != '0) begin
          op.shift  = 1'b1;
          e_byte    = oldest;
          fill_next = fill - sds_pkg::FILL_W'(1);
        end else begin
          e_kind = sds_pkg::KIND_END;
          e_last = 1'b1;
          done   = 1'b1;
        end
      end else if (len == '0) begin
        emits = 1'b1;
        if (fill != '0) begin
          op.shift  = 1'b1;
          e_byte    = oldest;
          fill_next = fill - sds_pkg::FILL_W'(1);
        end else begin
          e_byte = pend_data;
          e_last = 1'b1;
          done   = 1'b1;
        end
      end else if (fill > len) begin
        // length was lowered: drain down to a full window first
        emits     = 1'b1;
        op.shift  = 1'b1;
        e_byte    = oldest;
        fill_next = fill - sds_pkg::FILL_W'(1);
      end else if (fill == len) begin
        // pop oldest and append in the same step
        emits    = 1'b1;
        op.shift = 1'b1;
        op.load  = 1'b1;
        op.pos   = sds_pkg::POS_W'(len - sds_pkg::FILL_W'(1));
        e_byte   = oldest;
        if (match) begin
          owe_delim_next = 1'b1;
        end else begin
          e_last = 1'b1;
          done   = 1'b1;
        end
      end else begin
        op.load   = 1'b1;
        op.pos    = fill[sds_pkg::POS_W-1:0];
        fill_next = fill_inc;
        done      = 1'b1;
        if ((fill_inc == len) && match) begin
          emits     = 1'b1;
          e_kind    = sds_pkg::KIND_DELIM;
          e_last    = 1'b1;
          fill_next = '0;
        end
      end
    end
  end

  assign emit_ok  = !out_valid || !out_stall;
  assign go       = pend_valid && (emit_ok || !emits);
  assign in_stall = pend_valid && !(go && done);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      owe_delim  <= 1'b0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (go) begin
        fill      <= fill_next;
        owe_delim <= owe_delim_next;
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (go && done) begin
        pend_valid <= 1'b0;
      end
      if (go && emits) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_data <= data_byte;
      pend_eos  <= end_of_stream;
    end
    if (go && emits) begin
      out_byte    <= e_byte;
      kind        <= e_kind;
      last_of_run <= e_last;
    end
  end

  `SDS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= sds_pkg::FILL_W'(sds_pkg::MAX_DELIM), "window fill above limit")
  `SDS_ASSERT_IMP(a_owe_has_req, clk, rst, owe_delim, pend_valid, "delimiter owed without a request")
  `SDS_ASSERT_IMP(a_end_is_last, clk, rst, out_valid && (kind == sds_pkg::KIND_END), last_of_run, "end marker not last")
  `SDS_ASSERT_NXT(a_delim_clears, clk, rst, go && emits && (e_kind == sds_pkg::KIND_DELIM), fill == '0, "window not cleared on delimiter")

endmodule

@@ sv/sds_cell.sv @@
// ----------------------------------------------------------------------------
// Window cell
// Holds one window byte, takes its right neighbor on a shift or the new
// byte on a load, and flags whether its next value equals its delimiter byte.
// ----------------------------------------------------------------------------
module sds_cell (
  input  logic                      clk,
  input  logic                      en,
  input  sds_pkg::cell_op_t         op,
  input  logic [sds_pkg::POS_W-1:0] idx,
  input  logic [sds_pkg::BYTE_W-1:0] neighbor,
  input  logic [sds_pkg::BYTE_W-1:0] delim_byte,
  output logic [sds_pkg::BYTE_W-1:0] value,
  output logic                      hit
);

  logic [sds_pkg::BYTE_W-1:0] value_next;

  always_comb begin
    value_next = value;
    if (op.shift) begin
      value_next = neighbor;
    end
    if (op.load && (op.pos == idx)) begin
      value_next = op.data;
    end
  end

  // compare against the post-step value so a match is known in the same cycle
  assign hit = (value_next == delim_byte);

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule

@@ sv/sds_window.sv @@
// ----------------------------------------------------------------------------
// Delimiter window
// Row of cells, index 0 oldest; reduces the per-cell hits over the active
// delimiter length into one match flag.
// ----------------------------------------------------------------------------
module sds_window (
  input  logic                          clk,
  input  logic                          en,
  input  sds_pkg::cell_op_t             op,
  input  logic [sds_pkg::DELIM_W-1:0]   delim,
  input  logic [sds_pkg::MAX_DELIM-1:0] active,
  output logic [sds_pkg::BYTE_W-1:0]    oldest,
  output logic                          match
);

  logic [sds_pkg::BYTE_W-1:0]    values [sds_pkg::MAX_DELIM];
  logic [sds_pkg::MAX_DELIM-1:0] hits;

  for (genvar i = 0; i < sds_pkg::MAX_DELIM; i++) begin : g_cell
    logic [sds_pkg::BYTE_W-1:0] neighbor;

    if (i == sds_pkg::MAX_DELIM - 1) begin : g_tail
      assign neighbor = '0;
    end else begin : g_link
      assign neighbor = values[i+1];
    end

    sds_cell u_cell (
      .clk        (clk),
      .en         (en),
      .op         (op),
      .idx        (sds_pkg::POS_W'(i)),
      .neighbor   (neighbor),
      .delim_byte (delim[i*sds_pkg::BYTE_W +: sds_pkg::BYTE_W]),
      .value      (values[i]),
      .hit        (hits[i])
    );
  end

  assign oldest = values[0];
  assign match  = &(hits | ~active);

endmodule
